// File: rtl/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared constants, register indexes and the queued item type.
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam int CODE_BITS_LIMIT_DEF = 12;
  localparam int CLR_CODE            = 256;
  localparam int END_CODE            = 257;
  localparam int FIRST_FREE          = 258;
  localparam int START_WIDTH         = 9;
  localparam int WIDTH_CAP_RESET     = 12;

  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CODE_BITS   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_WHEN_FULL = 1'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } item_t;

endpackage

// File: rtl/lzwc_in_queue.sv
// ----------------------------------------------------------------------------
// LZW input queue
// Two-entry queue that takes input requests and hands them to the engine.
// ----------------------------------------------------------------------------
module lzwc_in_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lzw_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_pop,
  output lzw_pkg::item_t q_item
);

  lzw_pkg::item_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rptr];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/lzwc_engine.sv
// ----------------------------------------------------------------------------
// LZW engine
// Dictionary walk, insertion, width control and result emission.
// ----------------------------------------------------------------------------
module lzwc_engine #(
  parameter int CODE_BITS_LIMIT = lzw_pkg::CODE_BITS_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  lzw_pkg::item_t                      q_item,
  input  logic                                cfg_we,
  input  logic [lzw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lzw_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [CODE_BITS_LIMIT-1:0]          out_code,
  output logic [$clog2(CODE_BITS_LIMIT+1)-1:0] out_width,
  output logic                                run_last,
  output logic                                is_end_code
);

  localparam int CB    = CODE_BITS_LIMIT;
  localparam int NW    = CB + 1;
  localparam int WW    = $clog2(CB + 1);
  localparam int DEPTH = 1 << CB;

  localparam logic [CB-1:0] C_CLEAR = CB'(lzw_pkg::CLR_CODE);
  localparam logic [CB-1:0] C_END   = CB'(lzw_pkg::END_CODE);
  localparam logic [NW-1:0] C_FIRST = NW'(lzw_pkg::FIRST_FREE);
  localparam logic [WW-1:0] W_START = WW'(lzw_pkg::START_WIDTH);
  localparam logic [NW-1:0] N_DEPTH = NW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_FC, S_PROBE, S_MISS, S_CLR, S_LAST_PFX, S_LAST_END
  } state_t;

  state_t state;

  logic [CB-1:0]    fc_mem  [DEPTH];
  logic [CB-1:0]    sib_mem [DEPTH];
  logic [CB+7:0]    ent_mem [DEPTH];
  logic [CB-1:0]    fc_rd;
  logic [CB-1:0]    sib_rd;
  logic [CB+7:0]    ent_rd;

  logic [3:0]       width_cap;
  logic             clr_full;
  logic [NW-1:0]    nf;
  logic [WW-1:0]    width;
  logic             frozen;
  logic [CB-1:0]    prefix;
  logic             in_stream;
  logic [7:0]       cur_byte;
  logic             cur_last;
  logic [CB-1:0]    cand;
  logic [CB-1:0]    head;

  logic [WW-1:0]    eff_max;
  logic             slot_free;
  logic [CB-1:0]    probe_addr;
  logic             cand_ok;
  logic             byte_hit;
  logic [NW-1:0]    nf_inc;
  logic             can_add;
  logic             at_full;
  logic             clr_follow;
  logic             wr_en;
  logic [CB-1:0]    nf_idx;

  always_comb begin
    if (int'(width_cap) < lzw_pkg::START_WIDTH) eff_max = W_START;
    else if (int'(width_cap) > CB) eff_max = WW'(CB);
    else eff_max = WW'(width_cap);
  end

  assign slot_free  = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign probe_addr = (state == S_FC) ? fc_rd : sib_rd;
  assign cand_ok    = ({1'b0, cand} >= C_FIRST) && ({1'b0, cand} < nf) &&
                      (ent_rd[CB+7:8] == prefix);
  assign byte_hit   = (ent_rd[7:0] == cur_byte);
  assign nf_inc     = nf + NW'(1);
  assign nf_idx     = nf[CB-1:0];
  assign can_add    = !frozen && (nf < N_DEPTH);
  assign at_full    = (nf_inc == (NW'(1) << width));
  assign clr_follow = can_add && at_full && (width >= eff_max) && clr_full;
  assign wr_en      = (state == S_MISS) && slot_free && can_add;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[nf_idx] <= {prefix, cur_byte};
      sib_mem[nf_idx] <= head;
      fc_mem[prefix]  <= nf_idx;
    end
    fc_rd  <= fc_mem[prefix];
    ent_rd <= ent_mem[probe_addr];
    sib_rd <= sib_mem[probe_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      width_cap <= 4'(lzw_pkg::WIDTH_CAP_RESET);
      clr_full  <= 1'b0;
      nf        <= C_FIRST;
      width     <= W_START;
      frozen    <= 1'b0;
      prefix    <= '0;
      in_stream <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lzw_pkg::REG_MAX_CODE_BITS:   width_cap <= cfg_data;
          lzw_pkg::REG_CLEAR_WHEN_FULL: clr_full <= cfg_data[0];
          default: ;
        endcase
      end
      if (slot_free) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_byte <= q_item.data_byte;
            cur_last <= q_item.stream_end;
            state    <= in_stream ? S_FC : S_FIRST;
          end
        end
        S_FIRST: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            out_code    <= C_CLEAR;
            out_width   <= width;
            run_last    <= !cur_last;
            is_end_code <= 1'b0;
            prefix      <= CB'(cur_byte);
            in_stream   <= 1'b1;
            state       <= cur_last ? S_LAST_PFX : S_IDLE;
          end
        end
        S_FC: begin
          head  <= fc_rd;
          cand  <= fc_rd;
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (cand_ok && byte_hit) begin
            prefix <= cand;
            state  <= cur_last ? S_LAST_PFX : S_IDLE;
          end else if (cand_ok) begin
            if (sib_rd < cand) cand <= sib_rd;
            else state <= S_MISS;
          end else begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            out_code    <= prefix;
            out_width   <= width;
            run_last    <= !clr_follow && !cur_last;
            is_end_code <= 1'b0;
            if (can_add) begin
              nf <= nf_inc;
              if (at_full) begin
                if (width < eff_max) width <= width + WW'(1);
                else if (!clr_full) frozen <= 1'b1;
              end
            end
            prefix <= CB'(cur_byte);
            state  <= clr_follow ? S_CLR : (cur_last ? S_LAST_PFX : S_IDLE);
          end
        end
        S_CLR: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            out_code    <= C_CLEAR;
            out_width   <= width;
            run_last    <= !cur_last;
            is_end_code <= 1'b0;
            nf          <= C_FIRST;
            width       <= W_START;
            state       <= cur_last ? S_LAST_PFX : S_IDLE;
          end
        end
        S_LAST_PFX: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            out_code    <= prefix;
            out_width   <= width;
            run_last    <= 1'b0;
            is_end_code <= 1'b0;
            state       <= S_LAST_END;
          end
        end
        S_LAST_END: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            out_code    <= C_END;
            out_width   <= width;
            run_last    <= 1'b1;
            is_end_code <= 1'b1;
            nf          <= C_FIRST;
            width       <= W_START;
            frozen      <= 1'b0;
            prefix      <= '0;
            in_stream   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_nf_range: assert property (@(posedge clk) disable iff (rst)
    (nf >= C_FIRST) && (nf <= N_DEPTH))
    else $error("next free code out of range");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (width >= W_START) && (width <= WW'(CB)))
    else $error("code width out of range");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_end_code) |-> run_last)
    else $error("end code not marked last");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (state == S_LAST_END && slot_free) |=> (!in_stream && nf == C_FIRST))
    else $error("stream end did not restart state");

endmodule

// File: rtl/lzw_compressor.sv
// ----------------------------------------------------------------------------
// LZW compressor top level
// Input queue feeding the dictionary engine; zero to four codes per request.
// ----------------------------------------------------------------------------
// Flow: a request is popped from the queue once the engine is idle; its first
// code is registered in S_FIRST for a stream's first byte, else in S_MISS after
// S_FC and S_PROBE, with a further probe per sibling code walked in the trie.
// Output stall holds the engine. No new request is taken until the last one is
// done; each further code (clear at full, final prefix, end) has its own state.
// Reset: control state clears at once; the dictionary is emptied by the fill
// count, with no clearing pass.
module lzw_compressor #(
  parameter int CODE_BITS_LIMIT = lzw_pkg::CODE_BITS_LIMIT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           data_byte,
  input  logic                                 stream_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [CODE_BITS_LIMIT-1:0]           out_code,
  output logic [$clog2(CODE_BITS_LIMIT+1)-1:0] out_width,
  output logic                                 run_last,
  output logic                                 is_end_code,
  input  logic                                 cfg_we,
  input  logic [lzw_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lzw_pkg::CFG_DATA_W-1:0]       cfg_data
);

  lzw_pkg::item_t in_item;
  lzw_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign in_item.data_byte  = data_byte;
  assign in_item.stream_end = stream_end;

  lzwc_in_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lzwc_engine #(
    .CODE_BITS_LIMIT (CODE_BITS_LIMIT)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_code    (out_code),
    .out_width   (out_width),
    .run_last    (run_last),
    .is_end_code (is_end_code)
  );

endmodule

// File: sim/lzw_compressor_tb.sv
// ----------------------------------------------------------------------------
// LZW compressor testbench
// Drives byte streams under several width and overflow settings and checks
// every emitted code, width and flag against an in-bench dictionary model.
// Random idling on both sides, a long output hold-off and idle pauses.
// ----------------------------------------------------------------------------
module lzw_compressor_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DICT_SIZE   = 1 << lzw_pkg::CODE_BITS_LIMIT_DEF;

  typedef struct {
    logic [11:0] code;
    logic [3:0]  width;
    logic        last;
    logic        is_end;
  } code_rec_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  data_byte = 0;
  logic        stream_end = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [11:0] out_code;
  logic [3:0]  out_width;
  logic        run_last;
  logic        is_end_code;
  logic        cfg_we = 0;
  logic [lzw_pkg::CFG_INDEX_W-1:0] cfg_index = lzw_pkg::REG_MAX_CODE_BITS;
  logic [lzw_pkg::CFG_DATA_W-1:0]  cfg_data = 0;

  lzw_pkg::item_t pending_bytes[$];
  code_rec_t      expected_codes[$];
  int        cycle_count = 0;
  int        mismatches = 0;
  int        codes_seen = 0;
  int        hold_cycles = 0;
  bit        held_once = 0;

  // compressor state copy
  int        dict[int];
  int        next_code;
  int        cur_width;
  bit        frozen;
  bit        in_run;
  int        prefix;
  int        cap_reg;
  bit        clear_reg;

  lzw_compressor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .stream_end(stream_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code(out_code), .out_width(out_width),
    .run_last(run_last), .is_end_code(is_end_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit calm();
    return cycle_count >= 1000 && cycle_count < 1600;
  endfunction

  task automatic restart_dict();
    dict.delete();
    next_code = lzw_pkg::FIRST_FREE;
    cur_width = lzw_pkg::START_WIDTH;
    frozen = 0;
    prefix = 0;
    in_run = 0;
  endtask

  task automatic compress_byte(input logic [7:0] b, input logic fin);
    code_rec_t recs[$];
    int key;
    int top;
    top = cap_reg < lzw_pkg::START_WIDTH ? lzw_pkg::START_WIDTH :
          (cap_reg > lzw_pkg::CODE_BITS_LIMIT_DEF ? lzw_pkg::CODE_BITS_LIMIT_DEF : cap_reg);
    if (!in_run) begin
      recs.insert(recs.size(), '{12'(lzw_pkg::CLR_CODE), 4'(cur_width), 1'b0, 1'b0});
      prefix = b;
      in_run = 1;
    end else begin
      key = (prefix << 8) | b;
      if (dict.exists(key)) begin
        prefix = dict[key];
      end else begin
        recs.insert(recs.size(), '{12'(prefix), 4'(cur_width), 1'b0, 1'b0});
        if (!frozen && next_code < DICT_SIZE) begin
          dict[key] = next_code;
          next_code++;
          if (next_code == (1 << cur_width)) begin
            if (cur_width < top) begin
              cur_width++;
            end else if (clear_reg) begin
              recs.insert(recs.size(),
                          '{12'(lzw_pkg::CLR_CODE), 4'(cur_width), 1'b0, 1'b0});
              dict.delete();
              next_code = lzw_pkg::FIRST_FREE;
              cur_width = lzw_pkg::START_WIDTH;
            end else begin
              frozen = 1;
            end
          end
        end
        prefix = b;
      end
    end
    if (fin) begin
      recs.insert(recs.size(), '{12'(prefix), 4'(cur_width), 1'b0, 1'b0});
      recs.insert(recs.size(), '{12'(lzw_pkg::END_CODE), 4'(cur_width), 1'b0, 1'b1});
      restart_dict();
    end
    if (recs.size() > 0) recs[recs.size()-1].last = 1;
    foreach (recs[i]) expected_codes.insert(expected_codes.size(), recs[i]);
  endtask

  // request driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lzw_compressor verification failed");
      $finish;
    end else if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) compress_byte(data_byte, stream_end);
      if (pending_bytes.size() > 0 && (calm() || $urandom_range(0, 99) >= 29)) begin
        data_byte <= pending_bytes[0].data_byte;
        stream_end <= pending_bytes[0].stream_end;
        in_valid <= 1;
        void'(pending_bytes.pop_front());
      end else begin
        in_valid <= 0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    code_rec_t e;
    if (!rst && out_valid && !out_stall) begin
      codes_seen++;
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected code %0d width %0d", out_code, out_width);
      end else begin
        e = expected_codes.pop_front();
        if (out_code !== e.code || out_width !== e.width || run_last !== e.last ||
            is_end_code !== e.is_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch code/width/last/end: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     e.code, e.width, e.last, e.is_end,
                     out_code, out_width, run_last, is_end_code);
        end
      end
      if (codes_seen == 120 && !held_once) begin
        held_once = 1;
        hold_cycles = 300;
      end
    end
    if (rst) begin
      out_stall <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1;
    end else begin
      out_stall <= !calm() && $urandom_range(0, 99) < 29;
    end
  end

  task automatic settle();
    while (pending_bytes.size() > 0 || in_valid || expected_codes.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lzw_pkg::CFG_INDEX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= lzw_pkg::CFG_DATA_W'(val);
    if (idx == lzw_pkg::REG_MAX_CODE_BITS) cap_reg = val & 15;
    else clear_reg = val[0];
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    pending_bytes.insert(pending_bytes.size(), '{data_byte: b, stream_end: fin});
  endtask

  task automatic queue_random(input int count, input bit close, input int span);
    for (int i = 0; i < count; i++)
      queue_byte(8'($urandom_range(0, span)), close && i == count - 1);
  endtask

  task automatic queue_ramp(input int count, input int start);
    for (int i = 0; i < count; i++)
      queue_byte(8'(start + i), i == count - 1);
  endtask

  initial begin
    int len;
    cap_reg = lzw_pkg::WIDTH_CAP_RESET;
    clear_reg = 0;
    restart_dict();
    repeat (9) @(posedge clk);
    rst <= 0;

    // single-byte streams, repeated bytes, byte extremes
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b1);
    repeat (4) queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    for (int i = 0; i < 4; i++) queue_byte(i[0] ? 8'hAA : 8'h55, 1'b0);
    queue_byte(8'hFF, 1'b1);
    settle();

    // width register below range, clear at width 9 on the stream's last byte
    write_reg(lzw_pkg::REG_MAX_CODE_BITS, 0);
    write_reg(lzw_pkg::REG_CLEAR_WHEN_FULL, 1);
    queue_ramp(255, $urandom_range(0, 255));
    settle();

    // width register above range, short compressible streams
    write_reg(lzw_pkg::REG_MAX_CODE_BITS, 15);
    write_reg(lzw_pkg::REG_CLEAR_WHEN_FULL, 0);
    for (int s = 0; s < 3; s++) begin
      len = $urandom_range(1, 6);
      queue_random(len, 1, 3);
    end
    settle();

    if (mismatches == 0) begin
      $display("lzw_compressor verification clean");
    end else begin
      $display("lzw_compressor verification failed");
    end
    $finish;
  end
endmodule

// File: lzw_compressor.f
rtl/lzw_pkg.sv
rtl/lzwc_in_queue.sv
rtl/lzwc_engine.sv
rtl/lzw_compressor.sv
sim/lzw_compressor_tb.sv
